### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescape unit
// Parser phases, status codes, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Parser phase; codes above PH_UNI never occur and act as idle
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_UNI  = 3'd3
  } phase_t;

  // Status codes carried on the result channel
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_NOQ    = 3'd2;
  localparam logic [2:0] ST_TESC   = 3'd3;
  localparam logic [2:0] ST_TUNI   = 3'd4;
  localparam logic [2:0] ST_BADU   = 3'd5;
  localparam logic [2:0] ST_BADESC = 3'd6;
  localparam logic [2:0] ST_UNTERM = 3'd7;

  // Largest code point accepted from a \u escape
  localparam logic [15:0] UNI_MAX    = 16'h007F;
  // Digit count of a \u escape and the hex_count value of its last digit
  localparam int unsigned HEX_DIGITS = 4;
  localparam logic [1:0]  HEX_LAST   = 2'(HEX_DIGITS - 1);

  // Characters that steer the parser
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Control bytes produced by escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // One input beat
  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic       end_of_input;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
  } res_t;

  // Parser state carried from beat to beat
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_count;
    logic [15:0] hex_value;
    logic        hex_bad;
  } state_t;

  // Hex digit decode: bit 4 flags a non-hex byte, bits 3:0 the digit (0 if bad)
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else begin
      d = 5'b1_0000;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### hdl/jsu_intf.sv
// ----------------------------------------------------------------------------
// jsu_intf: valid/ready channels of the JSON string unescape unit
// Input channel carries raw bytes, result channel carries decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       first_byte;
  logic       end_of_input;

  modport source (output valid, byte_in, first_byte, end_of_input, input ready);
  modport sink   (input valid, byte_in, first_byte, end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] status;

  modport source (output valid, out_byte, out_valid, status, input ready);
  modport sink   (input valid, out_byte, out_valid, status, output ready);
endinterface

`default_nettype wire

### hdl/json_string_unescape_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_unit: JSON string unescaper, one byte per cycle unless out_ch stalls
// Registers each input beat, runs one unescape step and registers the result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  in_ch     in   valid / ready       byte_in[7:0], first_byte, end_of_input
//  out_ch    out  valid / ready       out_byte[7:0], out_valid, status[2:0]
//
//  Each input beat gives exactly one result beat, via the input and result registers.
//  Throughput is one beat per cycle while out_ch.ready is high; the parser state
//  loop closes through the decode step between the input and result registers.
//  Synchronous active-low reset clears both valid flags and the parser to idle.
//  A stalled result holds in its register; in_ch.ready drops only when both
//  the input and the result register are full and out_ch.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_unit import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  item_t  item_r;
  logic   in_vld_r;
  state_t st_r;
  state_t st_nxt;
  res_t   res_r;
  res_t   res_nxt;
  logic   out_vld_r;
  logic   adv;
  logic   in_acc;

  // Advance when a beat waits and the result register frees up
  assign adv    = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_vld_r || adv;

  jsu_decode u_decode (
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.byte_in      <= in_ch.byte_in;
      item_r.first_byte   <= in_ch.first_byte;
      item_r.end_of_input <= in_ch.end_of_input;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.hex_count <= 2'd0;
      st_r.hex_value <= 16'h0000;
      st_r.hex_bad   <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_byte  = res_r.out_byte;
  assign out_ch.out_valid = res_r.out_valid;
  assign out_ch.status    = res_r.status;

`ifndef ASSERT_OFF
  a_byte_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.out_valid |-> res_r.status == ST_RUN)
    else $error("decoded byte emitted with a final status");

  a_byte_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.out_valid |-> res_r.out_byte == 8'h00)
    else $error("out_byte nonzero without a decoded byte");

  a_count_clear_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_STR || st_r.phase == PH_ESC) |-> st_r.hex_count == 2'd0)
    else $error("hex digit count left over in a string phase");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced beat did not reach the result register");
`endif

endmodule

`default_nettype wire

### hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode: per-byte unescape step
// Computes the result beat and the next parser state from one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  item_t  item,
  input  state_t st,
  output state_t st_nxt,
  output res_t   res
);

  logic [4:0]  dig;
  logic [15:0] hex_acc;
  logic        bad_acc;

  // Accumulate the next hex digit
  assign dig     = hex_digit(item.byte_in);
  assign hex_acc = {st.hex_value[11:0], dig[3:0]};
  assign bad_acc = st.hex_bad | dig[4];

  always_comb begin
    st_nxt        = st;
    res.out_byte  = 8'h00;
    res.out_valid = 1'b0;
    res.status    = ST_RUN;

    if (item.first_byte) begin
      // Restart overrides any phase
      st_nxt.hex_count = 2'd0;
      st_nxt.hex_value = 16'h0000;
      st_nxt.hex_bad   = 1'b0;
      if (item.end_of_input || item.byte_in != CH_QUOTE) begin
        st_nxt.phase = PH_IDLE;
        res.status   = ST_NOQ;
      end else begin
        st_nxt.phase = PH_STR;
      end
    end else begin
      case (st.phase)
        PH_STR: begin
          if (item.end_of_input) begin
            st_nxt.phase = PH_IDLE;
            res.status   = ST_UNTERM;
          end else if (item.byte_in == CH_QUOTE) begin
            st_nxt.phase = PH_IDLE;
            res.status   = ST_DONE;
          end else if (item.byte_in == CH_BSLSH) begin
            st_nxt.phase = PH_ESC;
          end else begin
            res.out_byte  = item.byte_in;
            res.out_valid = 1'b1;
          end
        end
        PH_ESC: begin
          if (item.end_of_input) begin
            st_nxt.phase = PH_IDLE;
            res.status   = ST_TESC;
          end else begin
            st_nxt.phase  = PH_STR;
            res.out_valid = 1'b1;
            case (item.byte_in)
              CH_QUOTE: res.out_byte = CH_QUOTE;
              CH_BSLSH: res.out_byte = CH_BSLSH;
              CH_SLASH: res.out_byte = CH_SLASH;
              CH_B:     res.out_byte = CTL_BS;
              CH_F:     res.out_byte = CTL_FF;
              CH_N:     res.out_byte = CTL_LF;
              CH_R:     res.out_byte = CTL_CR;
              CH_T:     res.out_byte = CTL_HT;
              CH_U: begin
                res.out_valid    = 1'b0;
                st_nxt.phase     = PH_UNI;
                st_nxt.hex_count = 2'd0;
                st_nxt.hex_value = 16'h0000;
                st_nxt.hex_bad   = 1'b0;
              end
              default: begin
                res.out_valid = 1'b0;
                st_nxt.phase  = PH_IDLE;
                res.status    = ST_BADESC;
              end
            endcase
          end
        end
        PH_UNI: begin
          if (item.end_of_input) begin
            st_nxt.phase = PH_IDLE;
            res.status   = ST_TUNI;
          end else begin
            st_nxt.hex_value = hex_acc;
            st_nxt.hex_bad   = bad_acc;
            if (st.hex_count == HEX_LAST) begin
              // Last digit: check and emit the code point
              st_nxt.hex_count = 2'd0;
              if (bad_acc || hex_acc > UNI_MAX) begin
                st_nxt.phase = PH_IDLE;
                res.status   = ST_BADU;
              end else begin
                st_nxt.phase  = PH_STR;
                res.out_byte  = hex_acc[7:0];
                res.out_valid = 1'b1;
              end
            end else begin
              st_nxt.hex_count = st.hex_count + 2'd1;
            end
          end
        end
        default: begin
          // Idle: hold state, report nothing
        end
      endcase
    end
  end

endmodule

`default_nettype wire
